@@ design/ipfl_pkg.sv @@
// Shared types and constants for the IPv4 forwarding block with a prefix route table.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ipfl_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LEN_W = 6;
	localparam int ENTRY_W = 32 + LEN_W + 32;
	localparam int ACC_W = 20;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);
	localparam logic [3:0] CSUM_LAST = 4'd9;

	typedef enum logic [2:0] {
		ACT_ADDED = 3'd0,
		ACT_FULL = 3'd1,
		ACT_LOCAL = 3'd2,
		ACT_FORWARD = 3'd3,
		ACT_TTL_ERR = 3'd4,
		ACT_NO_ROUTE = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_CSUM,
		S_FOLD,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic add_write;
		logic scan_start;
		logic scan_step;
		logic csum_start;
		logic csum_step;
		logic fold_step;
		logic out_load;
		action_t action;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mode;
		logic is_local;
		logic ttl_zero;
		logic count_zero;
		logic table_full;
		logic scan_last;
		logic found;
		logic csum_last;
		logic fold_done;
		logic out_busy;
	} dp_status_t;

	function automatic logic [31:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [31:0] m;
		if (len == '0) begin
			m = 32'h0;
		end else if (len >= MAX_LEN) begin
			m = 32'hffff_ffff;
		end else begin
			m = 32'hffff_ffff << (MAX_LEN - len);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

@@ design/ipv4_forward_lpm_core.sv @@
// Top level of the IPv4 forwarding block with a longest-prefix route table.
// Depends on ipfl_pkg, ipfl_ram, ipfl_datapath, ipfl_ctrl and ipfl_chk.
//
// The input channel (in_valid/in_ready) moves one word: either a route add
// (mode 0) or a 20-byte header to forward (mode 1). The output channel
// (out_valid/out_ready) returns one result word per input word, in order.
// local_address is written through cfg_we/cfg_data; the user is to write
// it only while the block is idle, and the block itself has no check for it.
// Items are handled one at a time. A route add passes through the check,
// add and finish states before out_valid rises. A local, TTL error or
// empty-table forward goes from the check state straight to finish. A
// forward that scans the stored entries reads one table entry per cycle
// from the single RAM read port, then the checksum adds one 16-bit header
// word per cycle and folds carries until no carry is left.
// The next word can be accepted in the cycle after the result is loaded.
// The finished result sits in an output register, so the next word is
// accepted while it waits; if the receiver stalls, the block holds the next
// result until the output register is free.
// Reset clears the table count, local_address and both valid flags; table
// contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_forward_lpm_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic mode,
	input wire logic [31:0] route_dest,
	input wire logic [5:0] route_prefix_len,
	input wire logic [31:0] route_next_hop,
	input wire logic [31:0] hdr_word0,
	input wire logic [31:0] hdr_word1,
	input wire logic [31:0] hdr_word2,
	input wire logic [31:0] hdr_word3,
	input wire logic [31:0] hdr_word4,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] action,
	output logic [31:0] next_hop,
	output logic [7:0] out_ttl,
	output logic [15:0] out_checksum
);

	ipfl_pkg::ctrl_cmd_t cmd;
	ipfl_pkg::dp_status_t status;
	logic fwd_ttl_ok;

	ipfl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	ipfl_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.mode(mode),
		.route_dest(route_dest),
		.route_prefix_len(route_prefix_len),
		.route_next_hop(route_next_hop),
		.hdr_word0(hdr_word0),
		.hdr_word1(hdr_word1),
		.hdr_word2(hdr_word2),
		.hdr_word3(hdr_word3),
		.hdr_word4(hdr_word4),
		.cmd(cmd),
		.status(status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.next_hop(next_hop),
		.out_ttl(out_ttl),
		.out_checksum(out_checksum)
	);

	ipfl_chk u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.out_valid(out_valid),
		.action(action),
		.out_ttl(out_ttl),
		.fwd_ttl_ok(fwd_ttl_ok)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in progress");

	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_ttl_ok)
		else $error("forward result with a wrapped TTL");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != ipfl_pkg::ACT_FORWARD)
		|-> (next_hop == 32'h0) && (out_ttl == 8'h0) && (out_checksum == 16'h0))
		else $error("non-forward result carries nonzero fields");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result loaded over a stalled result");
`endif

endmodule
`default_nettype wire

@@ design/ipfl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ipfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/ipfl_datapath.sv @@
// Datapath: item capture, route table, prefix scan, checksum and output register.
// Depends on ipfl_pkg and ipfl_ram.
`timescale 1ns / 1ps
`default_nettype none
module ipfl_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_data,
	input wire logic mode,
	input wire logic [31:0] route_dest,
	input wire logic [5:0] route_prefix_len,
	input wire logic [31:0] route_next_hop,
	input wire logic [31:0] hdr_word0,
	input wire logic [31:0] hdr_word1,
	input wire logic [31:0] hdr_word2,
	input wire logic [31:0] hdr_word3,
	input wire logic [31:0] hdr_word4,
	input wire ipfl_pkg::ctrl_cmd_t cmd,
	output ipfl_pkg::dp_status_t status,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] action,
	output logic [31:0] next_hop,
	output logic [7:0] out_ttl,
	output logic [15:0] out_checksum
);

	logic [31:0] local_q;
	logic mode_q;
	logic [31:0] rdest_q;
	logic [ipfl_pkg::LEN_W-1:0] rlen_q;
	logic [31:0] rhop_q;
	logic [31:0] hdr_q [5];
	logic [ipfl_pkg::CNT_W-1:0] count_q;
	logic [ipfl_pkg::IDX_W-1:0] rd_idx_q;
	logic rd_valid_s1;
	logic found_q;
	logic [ipfl_pkg::LEN_W-1:0] best_len_q;
	logic [31:0] best_hop_q;
	logic [3:0] csum_idx_q;
	logic [ipfl_pkg::ACC_W-1:0] acc_q;
	logic out_valid_q;
	logic [2:0] action_q;
	logic [31:0] next_hop_q;
	logic [7:0] ttl_q;
	logic [15:0] csum_q;

	logic [ipfl_pkg::ENTRY_W-1:0] rdata;
	logic [31:0] e_prefix;
	logic [ipfl_pkg::LEN_W-1:0] e_len;
	logic [31:0] e_hop;
	logic [31:0] e_mask;
	logic e_hit;
	logic [7:0] ttl_dec;
	logic [15:0] csum_word;
	logic table_full;
	logic [ipfl_pkg::LEN_W-1:0] sat_len;

	assign table_full = (count_q == ipfl_pkg::CNT_W'(ipfl_pkg::TABLE_DEPTH));
	assign sat_len = (route_prefix_len > ipfl_pkg::MAX_LEN) ? ipfl_pkg::MAX_LEN
		: route_prefix_len;
	assign ttl_dec = hdr_q[2][31:24] - 8'd1;

	ipfl_ram #(
		.WIDTH(ipfl_pkg::ENTRY_W),
		.DEPTH(ipfl_pkg::TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(cmd.add_write && !table_full),
		.waddr(count_q[ipfl_pkg::IDX_W-1:0]),
		.wdata({rdest_q, rlen_q, rhop_q}),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	assign e_prefix = rdata[ipfl_pkg::ENTRY_W-1 -: 32];
	assign e_len = rdata[32 +: ipfl_pkg::LEN_W];
	assign e_hop = rdata[31:0];
	assign e_mask = ipfl_pkg::prefix_mask(e_len);
	assign e_hit = ((hdr_q[4] & e_mask) == (e_prefix & e_mask))
		&& (!found_q || (e_len > best_len_q));

	always_comb begin
		case (csum_idx_q)
			4'd0: csum_word = hdr_q[0][31:16];
			4'd1: csum_word = hdr_q[0][15:0];
			4'd2: csum_word = hdr_q[1][31:16];
			4'd3: csum_word = hdr_q[1][15:0];
			4'd4: csum_word = {ttl_dec, hdr_q[2][23:16]};
			4'd6: csum_word = hdr_q[3][31:16];
			4'd7: csum_word = hdr_q[3][15:0];
			4'd8: csum_word = hdr_q[4][31:16];
			4'd9: csum_word = hdr_q[4][15:0];
			default: csum_word = 16'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= 32'h0;
			count_q <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				local_q <= cfg_data;
			end
			if (cmd.add_write && !table_full) begin
				count_q <= count_q + 1'b1;
			end
			rd_valid_s1 <= cmd.scan_step;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			rdest_q <= route_dest;
			rlen_q <= sat_len;
			rhop_q <= route_next_hop;
			hdr_q[0] <= hdr_word0;
			hdr_q[1] <= hdr_word1;
			hdr_q[2] <= hdr_word2;
			hdr_q[3] <= hdr_word3;
			hdr_q[4] <= hdr_word4;
		end
		if (cmd.scan_start) begin
			rd_idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.scan_step) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (rd_valid_s1 && e_hit) begin
				found_q <= 1'b1;
				best_len_q <= e_len;
				best_hop_q <= e_hop;
			end
		end
		if (cmd.csum_start) begin
			csum_idx_q <= 4'd0;
			acc_q <= '0;
		end else if (cmd.csum_step) begin
			csum_idx_q <= csum_idx_q + 4'd1;
			acc_q <= acc_q + ipfl_pkg::ACC_W'(csum_word);
		end else if (cmd.fold_step) begin
			acc_q <= ipfl_pkg::ACC_W'(acc_q[15:0]) + ipfl_pkg::ACC_W'(acc_q[19:16]);
		end
		if (cmd.out_load) begin
			action_q <= cmd.action;
			if (cmd.action == ipfl_pkg::ACT_FORWARD) begin
				next_hop_q <= best_hop_q;
				ttl_q <= ttl_dec;
				csum_q <= ~acc_q[15:0];
			end else begin
				next_hop_q <= 32'h0;
				ttl_q <= 8'h0;
				csum_q <= 16'h0;
			end
		end
	end

	always_comb begin
		status.mode = mode_q;
		status.is_local = (hdr_q[4] == local_q);
		status.ttl_zero = (hdr_q[2][31:24] == 8'h0);
		status.count_zero = (count_q == '0);
		status.table_full = table_full;
		status.scan_last = ((ipfl_pkg::CNT_W'(rd_idx_q) + 1'b1) == count_q);
		status.found = found_q;
		status.csum_last = (csum_idx_q == ipfl_pkg::CSUM_LAST);
		status.fold_done = (acc_q[19:16] == 4'h0);
		status.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign next_hop = next_hop_q;
	assign out_ttl = ttl_q;
	assign out_checksum = csum_q;

endmodule
`default_nettype wire

@@ design/ipfl_ctrl.sv @@
// Controller state machine that sequences route adds, table scans and checksums.
// Depends on ipfl_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module ipfl_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ipfl_pkg::dp_status_t status,
	output ipfl_pkg::ctrl_cmd_t cmd
);

	ipfl_pkg::state_t state_q, state_d;
	ipfl_pkg::action_t act_q, act_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipfl_pkg::S_IDLE;
			act_q <= ipfl_pkg::ACT_ADDED;
		end else begin
			state_q <= state_d;
			act_q <= act_d;
		end
	end

	always_comb begin
		state_d = state_q;
		act_d = act_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.action = act_q;
		case (state_q)
			ipfl_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ipfl_pkg::S_CHECK;
				end
			end
			ipfl_pkg::S_CHECK: begin
				if (!status.mode) begin
					state_d = ipfl_pkg::S_ADD;
				end else if (status.is_local) begin
					act_d = ipfl_pkg::ACT_LOCAL;
					state_d = ipfl_pkg::S_FINISH;
				end else if (status.ttl_zero) begin
					act_d = ipfl_pkg::ACT_TTL_ERR;
					state_d = ipfl_pkg::S_FINISH;
				end else if (status.count_zero) begin
					act_d = ipfl_pkg::ACT_NO_ROUTE;
					state_d = ipfl_pkg::S_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ipfl_pkg::S_SCAN;
				end
			end
			ipfl_pkg::S_ADD: begin
				cmd.add_write = 1'b1;
				act_d = status.table_full ? ipfl_pkg::ACT_FULL : ipfl_pkg::ACT_ADDED;
				state_d = ipfl_pkg::S_FINISH;
			end
			ipfl_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ipfl_pkg::S_DRAIN;
				end
			end
			ipfl_pkg::S_DRAIN: begin
				state_d = ipfl_pkg::S_DECIDE;
			end
			ipfl_pkg::S_DECIDE: begin
				if (status.found) begin
					cmd.csum_start = 1'b1;
					act_d = ipfl_pkg::ACT_FORWARD;
					state_d = ipfl_pkg::S_CSUM;
				end else begin
					act_d = ipfl_pkg::ACT_NO_ROUTE;
					state_d = ipfl_pkg::S_FINISH;
				end
			end
			ipfl_pkg::S_CSUM: begin
				cmd.csum_step = 1'b1;
				if (status.csum_last) begin
					state_d = ipfl_pkg::S_FOLD;
				end
			end
			ipfl_pkg::S_FOLD: begin
				if (status.fold_done) begin
					state_d = ipfl_pkg::S_FINISH;
				end else begin
					cmd.fold_step = 1'b1;
				end
			end
			ipfl_pkg::S_FINISH: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ipfl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ipfl_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/ipfl_forward_lpm_core_dummy_guard.sv @@
// Result checker that flags a forward result whose TTL has wrapped, once out_valid was high in an earlier cycle.
// Depends on ipfl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipfl_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic [2:0] action,
	input wire logic [7:0] out_ttl,
	output logic fwd_ttl_ok
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid) begin
			seen_q <= 1'b1;
		end
	end

	assign fwd_ttl_ok = !(out_valid && seen_q
		&& (action == ipfl_pkg::ACT_FORWARD) && (out_ttl == 8'hff));

endmodule
`default_nettype wire
